[rtl/rhpc_pkg.sv]
// ---------------------------------------------------------------------------
// rhpc_pkg
// Shared types and constants for the rgb hue pixel classifier: the work item
// that travels down the divider chain, configuration set, class codes.
// ---------------------------------------------------------------------------
`default_nettype none

package rhpc_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned HUE_W   = 9;
  localparam int unsigned QUO_W   = 6;   // sector fraction 0..60
  localparam int unsigned REM_W   = 14;  // diff * 60 fits below 2**14
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [1:0] CLASS_GRAY        = 2'd0;
  localparam logic [1:0] CLASS_GLYPH       = 2'd1;
  localparam logic [1:0] CLASS_SPACING     = 2'd2;
  localparam logic [1:0] CLASS_UNSUPPORTED = 2'd3;

  localparam logic [1:0] REG_GRAY_SAT_LIMIT   = 2'd0;
  localparam logic [1:0] REG_COLOR_SAT_FLOOR  = 2'd1;
  localparam logic [1:0] REG_COLOR_BRT_FLOOR  = 2'd2;

  localparam logic [7:0] GRAY_SAT_LIMIT_RST  = 8'd64;
  localparam logic [7:0] COLOR_SAT_FLOOR_RST = 8'd128;
  localparam logic [7:0] COLOR_BRT_FLOOR_RST = 8'd128;

  localparam logic [8:0] SECTOR_BASE_BLUE_MIN  = 9'd60;
  localparam logic [8:0] SECTOR_BASE_RED_MIN   = 9'd180;
  localparam logic [8:0] SECTOR_BASE_GREEN_MIN = 9'd300;

  localparam logic [8:0] GLYPH_HUE_LOW    = 9'd30;
  localparam logic [8:0] GLYPH_HUE_HIGH   = 9'd330;
  localparam logic [8:0] SPACING_HUE_LOW  = 9'd210;
  localparam logic [8:0] SPACING_HUE_HIGH = 9'd270;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [CHAN_W-1:0] dvs;
    logic [QUO_W-1:0]  quo;
    logic [HUE_W-1:0]  base;
    logic              neg;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bright;
  } work_t;

  typedef struct packed {
    logic [CHAN_W-1:0] gray_sat_limit;
    logic [CHAN_W-1:0] color_sat_floor;
    logic [CHAN_W-1:0] color_brt_floor;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/rhpc_front.sv]
// ---------------------------------------------------------------------------
// rhpc_front
// Input stage: max, min, sector choice and the scaled numerator for the
// hue fraction divide.
// ---------------------------------------------------------------------------
`default_nettype none

module rhpc_front import rhpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [CHAN_W-1:0] red,
  input  wire logic [CHAN_W-1:0] green,
  input  wire logic [CHAN_W-1:0] blue,
  input  wire logic              down_hold,
  output logic                   hold,
  output logic                   valid,
  output work_t                  item
);

  logic [CHAN_W-1:0] mx, mn, d, opa, opb, diff;
  logic [HUE_W-1:0]  base;
  logic [REM_W-1:0]  num;
  work_t             item_next;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;

    // smallest channel tested blue first, then red
    priority if (mn == blue) begin
      base = SECTOR_BASE_BLUE_MIN;
      opa  = green;
      opb  = red;
    end else if (mn == red) begin
      base = SECTOR_BASE_RED_MIN;
      opa  = blue;
      opb  = green;
    end else begin
      base = SECTOR_BASE_GREEN_MIN;
      opa  = red;
      opb  = blue;
    end

    diff = (opa >= opb) ? (opa - opb) : (opb - opa);
    // diff * 60 as (diff << 6) - (diff << 2)
    num  = (REM_W'(diff) << 6) - (REM_W'(diff) << 2);

    item_next.rem    = num;
    item_next.dvs    = d;
    item_next.quo    = '0;
    item_next.base   = base;
    item_next.neg    = (opa < opb);
    item_next.sat    = d;
    item_next.bright = mx;
  end

  assign hold = valid & down_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rhpc_div_cell.sv]
// ---------------------------------------------------------------------------
// rhpc_div_cell
// One restoring-division cell: settles one quotient bit of the hue fraction
// and hands the item to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module rhpc_div_cell import rhpc_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  input  wire work_t up_item,
  input  wire logic  down_hold,
  output logic       hold,
  output logic       valid,
  output work_t      item
);

  logic [REM_W-1:0] dvs_sh;
  work_t            item_next;

  always_comb begin
    dvs_sh    = REM_W'(up_item.dvs) << SHIFT;
    item_next = up_item;
    // zero divisor only with zero numerator, hue forced to zero later
    if (up_item.rem >= dvs_sh) begin
      item_next.rem = up_item.rem - dvs_sh;
      item_next.quo = up_item.quo | (QUO_W'(1) << SHIFT);
    end
  end

  assign hold = valid & down_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && up_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rhpc_back.sv]
// ---------------------------------------------------------------------------
// rhpc_back
// Output stage: final hue from sector base and fraction, class decision,
// result register toward the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module rhpc_back import rhpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  input  wire work_t              up_item,
  input  wire cfg_t               cfg,
  input  wire logic               out_stall,
  output logic                    hold,
  output logic                    out_valid,
  output logic [CLASS_W-1:0]      pixel_class,
  output logic [CHAN_W-1:0]       gray_level,
  output logic [HUE_W-1:0]        hue,
  output logic [CHAN_W-1:0]       saturation,
  output logic [CHAN_W-1:0]       brightness
);

  logic [HUE_W-1:0]   hue_next;
  logic [CLASS_W-1:0] class_next;
  logic [CHAN_W-1:0]  level_next;

  always_comb begin
    if (up_item.sat == '0) begin
      hue_next = '0;
    end else if (up_item.neg) begin
      hue_next = up_item.base - HUE_W'(up_item.quo);
    end else begin
      hue_next = up_item.base + HUE_W'(up_item.quo);
    end

    level_next = '0;
    priority if (up_item.sat < cfg.gray_sat_limit) begin
      class_next = CLASS_GRAY;
      level_next = up_item.bright;
    end else if (up_item.sat > cfg.color_sat_floor &&
                 up_item.bright > cfg.color_brt_floor) begin
      priority if (hue_next < GLYPH_HUE_LOW || hue_next >= GLYPH_HUE_HIGH) begin
        class_next = CLASS_GLYPH;
      end else if (hue_next > SPACING_HUE_LOW && hue_next <= SPACING_HUE_HIGH) begin
        class_next = CLASS_SPACING;
      end else begin
        class_next = CLASS_UNSUPPORTED;
      end
    end else begin
      class_next = CLASS_UNSUPPORTED;
    end
  end

  assign hold = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && up_valid) begin
      pixel_class <= class_next;
      gray_level  <= level_next;
      hue         <= hue_next;
      saturation  <= up_item.sat;
      brightness  <= up_item.bright;
    end
  end

endmodule

`default_nettype wire

[rtl/rgb_hue_pixel_classifier.sv]
// ---------------------------------------------------------------------------
// rgb_hue_pixel_classifier
// Integer HSV conversion and gray / marker classification of 8-bit pixels.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low and returns one result per
// pixel, in order: one input stage for max, min and the scaled sector
// numerator, a chain of six restoring-divide cells that each settle one bit
// of the hue fraction, and one output stage that forms the hue and the class.
// Every stage holds its own valid bit, so bubbles close up while the output
// is stalled. Thresholds are set through the APB port at byte addresses 0,
// 4 and 8 and should be written only while no pixel is in flight.
`default_nettype none

module rgb_hue_pixel_classifier import rhpc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAN_W-1:0]  red,
  input  wire logic [CHAN_W-1:0]  green,
  input  wire logic [CHAN_W-1:0]  blue,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CLASS_W-1:0]      pixel_class,
  output logic [CHAN_W-1:0]       gray_level,
  output logic [HUE_W-1:0]        hue,
  output logic [CHAN_W-1:0]       saturation,
  output logic [CHAN_W-1:0]       brightness
);

  localparam int unsigned NCELL = QUO_W;

  cfg_t       cfg;
  logic [1:0] reg_idx;
  logic       wr_en;

  logic  chain_valid [NCELL+1];
  work_t chain_item  [NCELL+1];
  logic  chain_hold  [NCELL+2];

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gray_sat_limit  <= GRAY_SAT_LIMIT_RST;
      cfg.color_sat_floor <= COLOR_SAT_FLOOR_RST;
      cfg.color_brt_floor <= COLOR_BRT_FLOOR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GRAY_SAT_LIMIT:  cfg.gray_sat_limit  <= pwdata[CHAN_W-1:0];
        REG_COLOR_SAT_FLOOR: cfg.color_sat_floor <= pwdata[CHAN_W-1:0];
        REG_COLOR_BRT_FLOOR: cfg.color_brt_floor <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRAY_SAT_LIMIT:  prdata = PDATA_W'(cfg.gray_sat_limit);
      REG_COLOR_SAT_FLOOR: prdata = PDATA_W'(cfg.color_sat_floor);
      REG_COLOR_BRT_FLOOR: prdata = PDATA_W'(cfg.color_brt_floor);
      default:             prdata = '0;
    endcase
  end

  // pixel pipeline
  rhpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .down_hold (chain_hold[1]),
    .hold      (chain_hold[0]),
    .valid     (chain_valid[0]),
    .item      (chain_item[0])
  );

  assign in_stall = chain_hold[0];

  // cell i settles quotient bit NCELL-1-i, most significant first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rhpc_div_cell #(
      .SHIFT (NCELL - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (chain_valid[i]),
      .up_item   (chain_item[i]),
      .down_hold (chain_hold[i+2]),
      .hold      (chain_hold[i+1]),
      .valid     (chain_valid[i+1]),
      .item      (chain_item[i+1])
    );
  end

  rhpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (chain_valid[NCELL]),
    .up_item     (chain_item[NCELL]),
    .cfg         (cfg),
    .out_stall   (out_stall),
    .hold        (chain_hold[NCELL+1]),
    .out_valid   (out_valid),
    .pixel_class (pixel_class),
    .gray_level  (gray_level),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness)
  );

endmodule

`default_nettype wire
